// ----- design/ntc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ntc_pkg: shared types and constants for the numeric type converter
// Type codes, payload structs and the per-item pipeline record.
// ---------------------------------------------------------------------------
package ntc_pkg;

  localparam logic [3:0] TY_U8  = 4'd0;
  localparam logic [3:0] TY_U16 = 4'd1;
  localparam logic [3:0] TY_U32 = 4'd2;
  localparam logic [3:0] TY_U64 = 4'd3;
  localparam logic [3:0] TY_S8  = 4'd4;
  localparam logic [3:0] TY_S16 = 4'd5;
  localparam logic [3:0] TY_S32 = 4'd6;
  localparam logic [3:0] TY_S64 = 4'd7;
  localparam logic [3:0] TY_F32 = 4'd8;
  localparam logic [3:0] TY_F64 = 4'd9;

  typedef struct packed {
    logic [63:0] source_bits;
    logic [3:0]  source_type;
    logic [3:0]  dest_type;
  } ntc_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        converted;
  } ntc_out_t;

  // Working record between stages.
  // After stage 2 the magnitude is normalized into mag[63] (for m != 0); value = mag * 2^(exp - 63).
  typedef struct packed {
    logic [63:0] src;
    logic [3:0]  st;
    logic [3:0]  dt;
    logic        bad;      // invalid code
    logic        neg;
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
    logic [51:0] frac;     // raw float fraction (NaN payload)
    logic [63:0] mag;
    logic signed [12:0] exp;
  } ntc_work_t;

  function automatic logic [63:0] width_mask(input logic [3:0] code);
    logic [63:0] m;
    begin
      case (code)
        TY_U8, TY_S8:   m = 64'h0000_0000_0000_00FF;
        TY_U16, TY_S16: m = 64'h0000_0000_0000_FFFF;
        TY_U32, TY_S32, TY_F32: m = 64'h0000_0000_FFFF_FFFF;
        default:        m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      width_mask = m;
    end
  endfunction

endpackage : ntc_pkg
`default_nettype wire

// ----- design/numeric_type_converter_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// numeric_type_converter_unit: integer/float type conversion pipeline
// Pipeline: an item passes the stage 1 to stage 4 registers in order from input to output transfer.
// Throughput: one conversion per cycle; four stages move together and hold
// on out stall, so an input is taken whenever the output register is free.
// Reset: synchronous rst clears all stage valid bits; payload is not reset.
// ---------------------------------------------------------------------------
module numeric_type_converter_unit
  import ntc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire ntc_in_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_stall,
  output      ntc_out_t out_data
);

  // Stage 1: decode and unpack. Stage 2: normalize (leading-one shift).
  // Stage 3: round and pack / shift to integer. Stage 4: merge into image.
  logic      v1, v2, v3, v4;
  ntc_work_t s1, s2;
  logic      adv;

  assign adv      = !(v4 && out_stall);
  assign in_stall = !adv;

  // ---------------- stage 1 ----------------
  ntc_work_t s1_next;
  always_comb begin
    logic [63:0] v;
    logic [63:0] sm;
    logic [10:0] ex;
    s1_next = '0;
    s1_next.src = in_data.source_bits;
    s1_next.st  = in_data.source_type;
    s1_next.dt  = in_data.dest_type;
    s1_next.bad = (in_data.source_type > TY_F64) || (in_data.dest_type > TY_F64);
    sm = width_mask(in_data.source_type);
    v  = in_data.source_bits & sm;
    ex = '0;
    case (in_data.source_type)
      TY_F32: begin
        s1_next.neg  = v[31];
        ex           = {3'b0, v[30:23]};
        s1_next.frac = {v[22:0], 29'b0};
        s1_next.is_nan = (ex == 11'd255) && (v[22:0] != '0);
        s1_next.is_inf = (ex == 11'd255) && (v[22:0] == '0);
        s1_next.mag  = {40'b0, (ex != '0), v[22:0]};
        s1_next.exp  = (ex == '0) ? -13'sd149 : $signed({2'b0, ex}) - 13'sd150;
      end
      TY_F64: begin
        s1_next.neg  = v[63];
        ex           = v[62:52];
        s1_next.frac = v[51:0];
        s1_next.is_nan = (ex == 11'h7FF) && (v[51:0] != '0);
        s1_next.is_inf = (ex == 11'h7FF) && (v[51:0] == '0);
        s1_next.mag  = {11'b0, (ex != '0), v[51:0]};
        s1_next.exp  = (ex == '0) ? -13'sd1074 : $signed({2'b0, ex}) - 13'sd1075;
      end
      default: begin
        if (in_data.source_type >= TY_S8) begin
          case (in_data.source_type)
            TY_S8:   s1_next.neg = v[7];
            TY_S16:  s1_next.neg = v[15];
            TY_S32:  s1_next.neg = v[31];
            default: s1_next.neg = v[63];
          endcase
        end
        if (s1_next.neg) v = v | ~sm;
        // integer value kept in frac-less form; mag is magnitude, exp = 0
        s1_next.mag = s1_next.neg ? (64'd0 - v) : v;
        s1_next.src = v; // sign- or zero-extended source value
        s1_next.exp = 13'sd0;
      end
    endcase
    s1_next.is_zero = (s1_next.mag == '0);
  end

  logic [63:0] src1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      s1   <= s1_next;
      src1 <= in_data.source_bits;
    end
  end

  // ---------------- stage 2: normalize ----------------
  ntc_work_t s2_next;
  logic [63:0] src2;
  logic [63:0] ival2; // integer source value (sign extended), for int->int
  always_comb begin
    logic [5:0] lz;
    logic       found;
    s2_next = s1;
    lz = '0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && s1.mag[i]) begin
        lz = 6'(63 - i);
        found = 1'b1;
      end
    end
    s2_next.mag = s1.mag << lz;
    s2_next.exp = s1.exp + 13'sd63 - $signed({7'b0, lz});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      s2    <= s2_next;
      src2  <= src1;
      ival2 <= s1.src;
    end
  end

  // ---------------- stage 3: round / integer shift ----------------
  // Value = mag * 2^(exp-63), mag[63] = 1 unless zero. exp is the unbiased
  // exponent of the leading one.
  logic [63:0] conv3, conv3_next;
  logic [63:0] src3;
  logic [3:0]  dt3;
  logic        bad3;

  always_comb begin
    int          M, bias, emax;
    logic signed [13:0] E, lsbpos, sh;
    logic [63:0] keep, rem, half, mx, lim, ires;
    logic [64:0] r;
    logic        huge;
    logic [63:0] imag;
    logic [63:0] sgn;
    conv3_next = '0;
    keep = '0; rem = '0; half = '0; r = '0; ires = '0;
    huge = 1'b0; imag = '0; sgn = '0; mx = '0; lim = '0;
    M = 23; bias = 127; emax = 255;
    E = '0; lsbpos = '0; sh = '0;
    if (s2.dt == TY_F64) begin
      M = 52; bias = 1023; emax = 2047;
    end
    if (s2.st < TY_F32 && s2.dt < TY_F32) begin
      conv3_next = ival2;
    end else if (s2.st >= TY_F32 && s2.dt == s2.st) begin
      conv3_next = src2;
    end else if (s2.dt >= TY_F32) begin
      sgn = s2.neg ? (64'd1 << (M + ((M == 23) ? 8 : 11))) : 64'd0;
      if (s2.is_nan) begin
        if (s2.dt == TY_F64)
          conv3_next = sgn | (64'h7FF << 52) | (64'd1 << 51) | {12'b0, s2.frac};
        else
          conv3_next = sgn | (64'hFF << 23) | (64'd1 << 22) | {41'b0, s2.frac[51:29]};
      end else if (s2.is_inf) begin
        conv3_next = sgn | (64'(emax) << M);
      end else if (s2.is_zero) begin
        conv3_next = sgn;
      end else begin
        E = 14'(s2.exp) + 14'(bias);
        if (E >= 14'(emax)) begin
          conv3_next = sgn | (64'(emax) << M);
        end else begin
          // bit position of kept lsb relative to mag bit 0
          lsbpos = (E >= 14'sd1) ? 14'(63 - M) : 14'(63 - M) + (14'sd1 - E);
          sh = lsbpos;
          if (sh >= 14'sd64) begin
            keep = '0;
            // sh == 64: mag itself is rem, half = 2^63
            if (sh == 14'sd64 && s2.mag > 64'h8000_0000_0000_0000) keep = 64'd1;
          end else begin
            keep = s2.mag >> sh[5:0];
            rem  = s2.mag & ((64'd1 << sh[5:0]) - 64'd1);
            half = 64'd1 << (sh[5:0] - 6'd1);
            if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
          end
          r = {1'b0, ((E >= 14'sd1) ? 64'(E - 14'sd1) : 64'd0) << M} + {1'b0, keep};
          if (r >= {1'b0, 64'(emax) << M}) r = {1'b0, 64'(emax) << M};
          conv3_next = sgn | r[63:0];
        end
      end
    end else begin
      // float -> integer, truncate toward zero, saturate at the limits, NaN gives 0
      if (s2.is_inf) huge = 1'b1;
      else if (s2.is_zero || s2.exp < 0) imag = '0;
      else if (s2.exp > 13'sd63) huge = 1'b1;
      else imag = s2.mag >> (6'd63 - 6'(s2.exp));
      mx  = width_mask(s2.dt);
      lim = (mx >> 1) + 64'd1;
      if (s2.is_nan) ires = '0;
      else if (s2.dt < TY_S8) ires = s2.neg ? 64'd0 : ((huge || imag > mx) ? mx : imag);
      else if (s2.neg) ires = (huge || imag > lim) ? lim : (64'd0 - imag);
      else ires = (huge || imag > lim - 64'd1) ? lim - 64'd1 : imag;
      conv3_next = ires;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      conv3 <= conv3_next;
      src3  <= src2;
      dt3   <= s2.dt;
      bad3  <= s2.bad;
    end
  end

  // ---------------- stage 4: merge into image ----------------
  ntc_out_t out_next;
  always_comb begin
    logic [63:0] dm;
    dm = width_mask(dt3);
    if (bad3) begin
      out_next.result_bits = src3;
      out_next.converted   = 1'b0;
    end else begin
      out_next.result_bits = (src3 & ~dm) | (conv3 & dm);
      out_next.converted   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      out_data <= out_next;
    end
  end

  assign out_valid = v4;

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && out_stall) |=> (v4 && $stable(out_data)))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v4 && out_stall))
    else $error("input stalled without output stall");
  a_bad_flag: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && bad3) |=> !out_data.converted)
    else $error("invalid code flagged converted");
`endif

endmodule : numeric_type_converter_unit
`default_nettype wire

// ----- tb/sv/numeric_type_converter_unit_checker.sv -----
// ---------------------------------------------------------------------------
// numeric_type_converter_unit_checker: conversion predictor and scoreboard
// Watches both channels, computes the expected image for every input
// transfer and compares each output transfer against the oldest one.
// ---------------------------------------------------------------------------
module numeric_type_converter_unit_checker
  import ntc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  ntc_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  ntc_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  ntc_out_t expected_q[$];

  function automatic int code_bits(logic [3:0] c);
    if (c == TY_F32) return 32;
    if (c == TY_F64) return 64;
    return 8 << c[1:0];
  endfunction

  function automatic logic [63:0] low_mask(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic int msb_pos(logic [63:0] m);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    return p;
  endfunction

  // sign * m * 2^e rounded to nearest even into a format of fb fraction bits
  function automatic logic [63:0] round_pack(bit neg, logic [63:0] m, int e, int fb,
                                             int emax, int bias);
    logic [63:0] sgn, keep, rem, half, r;
    int p, ex, lsb, sh;
    sgn = neg ? (64'd1 << (fb + ((fb == 23) ? 8 : 11))) : 64'd0;
    if (m == 0) return sgn;
    p = msb_pos(m);
    ex = p + e + bias;
    if (ex >= emax) return sgn | (64'(emax) << fb);
    lsb = (ex >= 1) ? (p + e - fb) : (1 - bias - fb);
    sh = lsb - e;
    if (sh <= 0) keep = m << (-sh);
    else if (sh >= 64) keep = 0;
    else begin
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = m >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
    end
    r = ((ex >= 1) ? 64'(ex - 1) : 64'd0) << fb;
    r = r + keep;
    if (r >= (64'(emax) << fb)) r = 64'(emax) << fb;
    return sgn | r;
  endfunction

  function automatic ntc_out_t convert(ntc_in_t it);
    ntc_out_t o;
    logic [63:0] src, v, sm, mag, conv, m, fr, lim, mx;
    bit neg, huge, wide;
    int ws, e, fb, cls;
    logic [10:0] ex, exm;
    src = it.source_bits;
    conv = 0;
    if (it.source_type > TY_F64 || it.dest_type > TY_F64) begin
      o.result_bits = src;
      o.converted = 1'b0;
      return o;
    end
    if (it.source_type < TY_F32) begin
      ws = code_bits(it.source_type);
      sm = low_mask(ws);
      v = src & sm;
      neg = 0;
      if (it.source_type >= TY_S8 && v[ws-1]) begin
        v |= ~sm;
        neg = 1;
      end
      mag = neg ? -v : v;
      if (it.dest_type < TY_F32) conv = v;
      else if (it.dest_type == TY_F32) conv = round_pack(neg, mag, 0, 23, 255, 127);
      else conv = round_pack(neg, mag, 0, 52, 2047, 1023);
    end else begin
      wide = (it.source_type == TY_F64);
      fb = wide ? 52 : 23;
      exm = wide ? 11'd2047 : 11'd255;
      v = wide ? src : {32'd0, src[31:0]};
      neg = wide ? v[63] : v[31];
      ex = 11'((v >> fb)) & exm;
      fr = v & low_mask(fb);
      m = fr;
      e = 0;
      cls = 0;
      if (ex == exm) cls = (fr != 0) ? 2 : 1;
      else if (ex == 0) e = wide ? -1074 : -149;
      else begin
        m = fr | (64'd1 << fb);
        e = int'(ex) - (wide ? 1075 : 150);
      end
      if (it.dest_type == it.source_type) conv = src;
      else if (it.dest_type < TY_F32) begin
        huge = 0;
        mag = 0;
        if (cls == 1) huge = 1;
        else if (cls == 0) begin
          if (e >= 64) huge = (m != 0);
          else if (e > 0 && (m >> (64 - e)) != 0) huge = 1;
          else if (e >= 0) mag = m << e;
          else if (e > -64) mag = m >> (-e);
        end
        ws = code_bits(it.dest_type);
        if (cls == 2) conv = 0;
        else if (it.dest_type < TY_S8) begin
          mx = low_mask(ws);
          conv = neg ? 64'd0 : ((huge || mag > mx) ? mx : mag);
        end else begin
          lim = 64'd1 << (ws - 1);
          if (neg) conv = (huge || mag > lim) ? lim : -mag;
          else conv = (huge || mag > lim - 1) ? lim - 1 : mag;
        end
      end else if (it.dest_type == TY_F64) begin
        if (cls == 2) conv = {neg, 11'h7FF, 1'b1, 51'd0} | (m << 29);
        else if (cls == 1) conv = {neg, 11'h7FF, 52'd0};
        else conv = round_pack(neg, m, e, 52, 2047, 1023);
      end else begin
        if (cls == 2) conv = {32'd0, neg, 8'hFF, 1'b1, 22'd0} | (m >> 29);
        else if (cls == 1) conv = {32'd0, neg, 8'hFF, 23'd0};
        else conv = round_pack(neg, m, e, 23, 255, 127);
      end
    end
    sm = low_mask(code_bits(it.dest_type));
    o.result_bits = (src & ~sm) | (conv & sm);
    o.converted = 1'b1;
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    ntc_out_t want;
    if (rst) begin
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(convert(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transfer: %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: exp bits %h conv %b, got bits %h conv %b",
                       want.result_bits, want.converted,
                       out_data.result_bits, out_data.converted);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/numeric_type_converter_unit_tb.sv -----
// ---------------------------------------------------------------------------
// numeric_type_converter_unit_tb: stimulus and verdict
// Directed corner values, then random integer/float conversions with random
// gaps and output stalls, including one long output hold-off.
// ---------------------------------------------------------------------------
module numeric_type_converter_unit_tb;
  import ntc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 5000;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  ntc_in_t in_data;
  ntc_out_t out_data;
  int fail_count, pending, idle_cycles;
  bit quiet, hold_done, stim_done;

  numeric_type_converter_unit uut (.*);

  numeric_type_converter_unit_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] pick_bits();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: b = 64'(b[7:0]);
      1: b = {$urandom, 1'b0, 8'($urandom_range(120, 255)), 23'($urandom)};
      2: b = {$urandom, 1'b1, 8'($urandom_range(120, 190)), 23'($urandom)};
      3: b = {b[63], 11'($urandom_range(1000, 1100)), b[51:0]};
      4: b = {b[63], 11'($urandom_range(850, 1200)), b[51:0]};
      5: b = {b[63], 11'h7FF, ($urandom_range(0, 1) ? 52'd0 : b[51:0])};
      6: b = {$urandom, b[31], 8'hFF, ($urandom_range(0, 1) ? 23'd0 : b[22:0])};
      7: b = {b[63], 11'd0, b[51:0]};
      8: b = {b[63:32], b[31], 8'd0, b[22:0]};
      default: ;
    endcase
    return b;
  endfunction

  task automatic send(logic [63:0] b, logic [3:0] s, logic [3:0] d);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{b, s, d};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver; one long hold-off after a fixed number of cycles
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (!hold_done && rx_cycles >= 300) begin
        out_stall <= 1'b1;
        repeat (40) @(negedge clk);
        hold_done = 1;
      end
      out_stall <= !quiet && !stim_done && $urandom_range(0, 99) < 13;
    end
  end

  // watchdog on accepted transfers
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** numeric_type_converter_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [3:0] s, d;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed corners
    send(64'hFFFF_FFFF_FFFF_FFFF, TY_S8, TY_F64);
    send(64'hFFFF_FFFF_FFFF_FFFF, TY_U64, TY_F32);
    send(64'h8000_0000_0000_0000, TY_S64, TY_F64);
    send(64'h0000_0000_0000_0000, TY_U8, TY_S64);
    send(64'h1234_5678_9ABC_DE80, TY_S8, TY_U32);
    send(64'h0000_0000_0100_0001, TY_U32, TY_F32);
    send(64'hAAAA_AAAA_7F80_0000, TY_F32, TY_S32);
    send(64'hAAAA_AAAA_FF80_0000, TY_F32, TY_U16);
    send(64'hAAAA_AAAA_7FC0_0001, TY_F32, TY_S64);
    send(64'hAAAA_AAAA_7F80_0123, TY_F32, TY_F64);
    send(64'h7FF0_0000_0000_0001, TY_F64, TY_F32);
    send(64'h7FF4_0000_0000_0001, TY_F64, TY_F64);
    send(64'h47F0_0000_0000_0000, TY_F64, TY_F32);
    send(64'h3690_0000_0000_0000, TY_F64, TY_F32);
    send(64'h8000_0000_0000_0001, TY_F64, TY_F32);
    send(64'hC3E0_0000_0000_0000, TY_F64, TY_S64);
    send(64'hC3E0_0000_0000_0001, TY_F64, TY_S64);
    send(64'h43F0_0000_0000_0000, TY_F64, TY_U64);
    send(64'hBFEF_FFFF_FFFF_FFFF, TY_F64, TY_S8);
    send(64'h0000_0000_0000_0001, TY_F32, TY_F64);
    send(64'h0123_4567_89AB_CDEF, 4'd10, TY_U8);
    send(64'h0123_4567_89AB_CDEF, TY_F64, 4'd15);
    // random part; one stretch in the middle without idling or output stalls
    for (int i = 0; i < 700; i++) begin
      quiet = (i >= 100 && i < 200);
      s = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      d = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      send(pick_bits(), s, d);
    end
    in_valid <= 1'b0;
    stim_done = 1;
    quiet = 0;
    while (chk.pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("** numeric_type_converter_unit: PASSED **");
    else $display("** numeric_type_converter_unit: FAILED **");
    $finish;
  end
endmodule

// ----- sim.f -----
design/ntc_pkg.sv
design/numeric_type_converter_unit.sv
tb/sv/numeric_type_converter_unit_checker.sv
tb/sv/numeric_type_converter_unit_tb.sv
